[rtl/stcb_pkg.sv]
// shared constants and types for the scrolling text console buffer
`timescale 1ns / 1ps
`default_nettype none

package stcb_pkg;

	localparam int COLUMNS_DEF = 16;
	localparam int ROWS_DEF    = 8;

	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 16;
	localparam int POS_W   = 8;

	localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_LBRACKET = 8'h5B;
	localparam logic [CHAR_W-1:0] CHAR_RBRACKET = 8'h5D;
	localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_PLAIN_PEN  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCENT_PEN = 2'd1;

	typedef enum logic [1:0] {
		MODE_PUT   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

endpackage

`default_nettype wire

[rtl/stcb_ram.sv]
// generic simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module stcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/scrolling_text_console_buffer_unit.sv]
// text console store with cursor, bracket colouring, line fill and row scroll
`timescale 1ns / 1ps
`default_nettype none

// Text console of ROWS x COLUMNS cells, each with a character and a 16-bit colour,
// held in two RAMs with registered reads and addressed through a circular row offset.
// After reset the block runs a clearing pass, one RAM write per cell, with in_stall high
// (configuration writes are taken at any time). One item at a time is worked on: a
// plain character, a bracket, an out-of-range read or an unused mode goes from ST_EXEC
// to ST_DONE, an in-range cell read passes through ST_READ, CR/LF pads the rest of a
// started line with spaces in ST_FILL, a scroll before a character (the colour copy
// of the bottom row and a second pass through the write step) goes through ST_SCROLL,
// and a clear writes every cell in ST_CLEAR through the shared RAM write address. A
// finished result waits in an output register while the next item is taken; an item
// that finishes while that result is still stalled waits for it.
module scrolling_text_console_buffer_unit #(
	parameter int COLUMNS = stcb_pkg::COLUMNS_DEF,
	parameter int ROWS    = stcb_pkg::ROWS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [stcb_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire [stcb_pkg::COLOR_W-1:0]         cfg_data,
	// input channel
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire [1:0]                           mode,
	input  wire [7:0]                           char_code,
	input  wire                                 end_of_string,
	input  wire [2:0]                           read_row,
	input  wire [3:0]                           read_col,
	// output channel
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic [stcb_pkg::POS_W-1:0]          cursor_pos,
	output logic [stcb_pkg::CHAR_W-1:0]         cell_char,
	output logic [stcb_pkg::COLOR_W-1:0]        cell_color
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int TW    = $clog2(ROWS);
	localparam int RW    = $clog2(ROWS + 1);
	localparam int CW    = $clog2(COLUMNS);
	localparam int CURW  = $clog2(CELLS + 1);

	localparam logic [AW-1:0]   COLS_A    = AW'(COLUMNS);
	localparam logic [AW-1:0]   CELLS_M1  = AW'(CELLS - 1);
	localparam logic [TW:0]     ROWS_T1   = (TW + 1)'(ROWS);
	localparam logic [TW-1:0]   LROW_LAST = TW'(ROWS - 1);
	localparam logic [TW-1:0]   TOP_MAX   = TW'(ROWS - 1);
	localparam logic [RW-1:0]   ROW_END   = RW'(ROWS);
	localparam logic [RW-1:0]   ROW_LAST  = RW'(ROWS - 1);
	localparam logic [CW-1:0]   COLS_M1   = CW'(COLUMNS - 1);
	localparam logic [CW:0]     SCR_END   = (CW + 1)'(COLUMNS);
	localparam logic [CURW-1:0] CUR_LAST  = CURW'((ROWS - 1) * COLUMNS);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_FILL,
		ST_SCROLL,
		ST_DONE
	} state_t;

	// logical row and column to ram address through the row offset
	function automatic logic [AW-1:0] phys_addr(input logic [TW-1:0] lrow,
			input logic [CW-1:0] col, input logic [TW-1:0] top);
		logic [TW:0]   sum;
		logic [TW-1:0] prow;
		sum = {1'b0, lrow} + {1'b0, top};
		if (sum >= ROWS_T1) begin
			sum = sum - ROWS_T1;
		end
		prow = sum[TW-1:0];
		return AW'(prow) * COLS_A + AW'(col);
	endfunction

	state_t state_q;

	logic [stcb_pkg::COLOR_W-1:0] plain_pen_q;
	logic [stcb_pkg::COLOR_W-1:0] accent_pen_q;

	logic [CURW-1:0] cursor_q;
	logic [RW-1:0]   cur_row_q;
	logic [CW-1:0]   cur_col_q;
	logic [TW-1:0]   top_q;
	logic            special_q;

	logic [AW-1:0]   clr_cnt_q;
	logic            clr_item_q;
	logic [CW:0]     scr_cnt_q;
	logic            scr_wen_s1;
	logic [CW-1:0]   scr_col_s1;

	stcb_pkg::mode_t           mode_q;
	logic [stcb_pkg::CHAR_W-1:0] char_q;
	logic                      eos_q;
	logic [2:0]                read_row_q;
	logic [3:0]                read_col_q;

	logic [stcb_pkg::CHAR_W-1:0]  res_char_q;
	logic [stcb_pkg::COLOR_W-1:0] res_color_q;
	logic                         out_valid_q;
	logic [stcb_pkg::POS_W-1:0]   cursor_pos_q;
	logic [stcb_pkg::CHAR_W-1:0]  cell_char_q;
	logic [stcb_pkg::COLOR_W-1:0] cell_color_q;

	// ram ports
	logic                         char_we;
	logic                         color_we;
	logic [AW-1:0]                waddr;
	logic [AW-1:0]                raddr;
	logic [stcb_pkg::CHAR_W-1:0]  char_wdata;
	logic [stcb_pkg::COLOR_W-1:0] color_wdata;
	logic [stcb_pkg::CHAR_W-1:0]  char_rdata;
	logic [stcb_pkg::COLOR_W-1:0] color_rdata;

	// decode of the held item
	logic            is_lbr;
	logic            is_rbr;
	logic            is_eol;
	logic            at_end;
	logic            rd_in_range;
	logic [TW+2:0]   rrow_w;
	logic [CW+3:0]   rcol_w;
	logic [TW-1:0]   rrow;
	logic [CW-1:0]   rcol;
	logic [TW-1:0]   crow;
	logic [AW-1:0]   cur_addr;
	logic [CURW+7:0] cursor_w;

	assign is_lbr   = (char_q == stcb_pkg::CHAR_LBRACKET);
	assign is_rbr   = (char_q == stcb_pkg::CHAR_RBRACKET);
	assign is_eol   = (char_q == stcb_pkg::CHAR_CR) || (char_q == stcb_pkg::CHAR_LF);
	assign at_end   = (cur_row_q == ROW_END);
	assign rd_in_range = (32'(read_row_q) < ROWS) && (32'(read_col_q) < COLUMNS);
	assign rrow_w   = {{TW{1'b0}}, read_row_q};
	assign rcol_w   = {{CW{1'b0}}, read_col_q};
	assign rrow     = rrow_w[TW-1:0];
	assign rcol     = rcol_w[CW-1:0];
	assign crow     = cur_row_q[TW-1:0];
	assign cur_addr = phys_addr(crow, cur_col_q, top_q);
	assign cursor_w = {8'b0, cursor_q};

	always_comb begin
		char_we     = 1'b0;
		color_we    = 1'b0;
		waddr       = cur_addr;
		raddr       = '0;
		char_wdata  = char_q;
		color_wdata = special_q ? accent_pen_q : plain_pen_q;
		unique case (state_q)
			ST_CLEAR: begin
				char_we     = 1'b1;
				color_we    = 1'b1;
				waddr       = clr_cnt_q;
				char_wdata  = stcb_pkg::CHAR_SPACE;
				color_wdata = '0;
			end
			ST_EXEC: begin
				if (mode_q == stcb_pkg::MODE_PUT && !is_lbr && !is_rbr && !is_eol
						&& !at_end) begin
					char_we  = 1'b1;
					color_we = 1'b1;
				end
				raddr = phys_addr(rrow, rcol, top_q);
			end
			ST_FILL: begin
				char_we    = 1'b1;
				char_wdata = stcb_pkg::CHAR_SPACE;
			end
			ST_SCROLL: begin
				// copy bottom row colours into the row that becomes the new bottom
				raddr       = phys_addr(LROW_LAST, scr_cnt_q[CW-1:0], top_q);
				waddr       = phys_addr('0, scr_col_s1, top_q);
				char_we     = scr_wen_s1;
				color_we    = scr_wen_s1;
				char_wdata  = stcb_pkg::CHAR_SPACE;
				color_wdata = color_rdata;
			end
			default: begin
			end
		endcase
	end

	stcb_ram #(
		.WIDTH (stcb_pkg::CHAR_W),
		.DEPTH (CELLS)
	) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.waddr (waddr),
		.wdata (char_wdata),
		.raddr (raddr),
		.rdata (char_rdata)
	);

	stcb_ram #(
		.WIDTH (stcb_pkg::COLOR_W),
		.DEPTH (CELLS)
	) u_color_ram (
		.clk   (clk),
		.we    (color_we),
		.waddr (waddr),
		.wdata (color_wdata),
		.raddr (raddr),
		.rdata (color_rdata)
	);

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			plain_pen_q     <= '0;
			accent_pen_q    <= '0;
			cursor_q        <= '0;
			cur_row_q       <= '0;
			cur_col_q       <= '0;
			top_q           <= '0;
			special_q       <= 1'b0;
			clr_cnt_q       <= '0;
			clr_item_q      <= 1'b0;
			scr_cnt_q       <= '0;
			scr_wen_s1      <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				priority if (cfg_index == stcb_pkg::REG_PLAIN_PEN) begin
					plain_pen_q <= cfg_data;
				end else if (cfg_index == stcb_pkg::REG_ACCENT_PEN) begin
					accent_pen_q <= cfg_data;
				end else begin
				end
			end

			// ST_DONE reloads the output register itself
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			scr_wen_s1 <= (state_q == ST_SCROLL) && (scr_cnt_q != SCR_END);

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == CELLS_M1) begin
						clr_cnt_q <= '0;
						state_q   <= clr_item_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (mode_q)
						stcb_pkg::MODE_PUT: begin
							priority if (is_lbr) begin
								special_q <= 1'b1;
								state_q   <= ST_DONE;
							end else if (is_rbr) begin
								special_q <= 1'b0;
								state_q   <= ST_DONE;
							end else if (is_eol) begin
								state_q <= (cur_col_q == '0) ? ST_DONE : ST_FILL;
							end else if (at_end) begin
								scr_cnt_q <= '0;
								state_q   <= ST_SCROLL;
							end else begin
								cursor_q <= cursor_q + 1'b1;
								if (cur_col_q == COLS_M1) begin
									cur_col_q <= '0;
									cur_row_q <= cur_row_q + 1'b1;
								end else begin
									cur_col_q <= cur_col_q + 1'b1;
								end
								state_q <= ST_DONE;
							end
						end
						stcb_pkg::MODE_READ: begin
							state_q <= rd_in_range ? ST_READ : ST_DONE;
						end
						stcb_pkg::MODE_CLEAR: begin
							clr_cnt_q  <= '0;
							clr_item_q <= 1'b1;
							state_q    <= ST_CLEAR;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_FILL: begin
					cursor_q <= cursor_q + 1'b1;
					if (cur_col_q == COLS_M1) begin
						cur_col_q <= '0;
						cur_row_q <= cur_row_q + 1'b1;
						state_q   <= ST_DONE;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				ST_SCROLL: begin
					if (scr_cnt_q != SCR_END) begin
						scr_cnt_q  <= scr_cnt_q + 1'b1;
					end else begin
						// last colour write lands this cycle, then rotate the rows
						top_q     <= (top_q == TOP_MAX) ? '0 : top_q + 1'b1;
						cur_row_q <= ROW_LAST;
						cur_col_q <= '0;
						cursor_q  <= CUR_LAST;
						state_q   <= ST_EXEC;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						clr_item_q  <= 1'b0;
						if (mode_q == stcb_pkg::MODE_PUT && eos_q) begin
							special_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item capture, read results and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q     <= stcb_pkg::mode_t'(mode);
			char_q     <= char_code;
			eos_q      <= end_of_string;
			read_row_q <= read_row;
			read_col_q <= read_col;
		end
		if (state_q == ST_EXEC) begin
			res_char_q  <= '0;
			res_color_q <= '0;
		end
		if (state_q == ST_READ) begin
			res_char_q  <= char_rdata;
			res_color_q <= color_rdata;
		end
		if (scr_cnt_q != SCR_END) begin
			scr_col_s1 <= scr_cnt_q[CW-1:0];
		end
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			cursor_pos_q <= cursor_w[7:0];
			cell_char_q  <= res_char_q;
			cell_color_q <= res_color_q;
		end
	end

endmodule

`default_nettype wire

[bench/tb_scrolling_text_console_buffer_unit.sv]
// self-checking testbench for the scrolling text console buffer unit
`timescale 1ns / 1ps

module tb_scrolling_text_console_buffer_unit;

	localparam int COLS  = 16;
	localparam int LINES = 8;
	localparam int CELLS = COLS * LINES;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [stcb_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [stcb_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int RANDOM_ITEMS  = 1125;
	localparam int PHASES        = 8;
	localparam int SETTLE_CYCLES = 150;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		logic [stcb_pkg::POS_W-1:0]   pos;
		logic [stcb_pkg::CHAR_W-1:0]  ch;
		logic [stcb_pkg::COLOR_W-1:0] color;
	} console_result_t;

	class console_scoreboard;
		logic [stcb_pkg::CHAR_W-1:0]  chars  [CELLS];
		logic [stcb_pkg::COLOR_W-1:0] colors [CELLS];
		int                 cursor;
		bit                 in_brackets;
		logic [stcb_pkg::COLOR_W-1:0] plain_pen;
		logic [stcb_pkg::COLOR_W-1:0] accent_pen;
		console_result_t    expected_q [$];
		int errors, checked, reads, clears, scrolls, line_ends;

		function new();
			plain_pen     = '0;
			accent_pen    = '0;
			cursor        = 0;
			in_brackets   = 1'b0;
			wipe_store();
		endfunction

		function void wipe_store();
			for (int k = 0; k < CELLS; k++) begin
				chars[k]  = stcb_pkg::CHAR_SPACE;
				colors[k] = '0;
			end
		endfunction

		function void write_register(logic [stcb_pkg::CFG_INDEX_W-1:0] idx,
				logic [stcb_pkg::COLOR_W-1:0] data);
			if (idx == stcb_pkg::REG_PLAIN_PEN)
				plain_pen = data;
			else if (idx == stcb_pkg::REG_ACCENT_PEN)
				accent_pen = data;
		endfunction

		function void place_char(logic [stcb_pkg::CHAR_W-1:0] c);
			if (c == stcb_pkg::CHAR_LBRACKET) begin
				in_brackets = 1'b1;
			end else if (c == stcb_pkg::CHAR_RBRACKET) begin
				in_brackets = 1'b0;
			end else if (c == stcb_pkg::CHAR_CR || c == stcb_pkg::CHAR_LF) begin
				line_ends++;
				while ((cursor % COLS) != 0 && cursor < CELLS) begin
					chars[cursor] = stcb_pkg::CHAR_SPACE;
					cursor++;
				end
			end else begin
				if (cursor >= CELLS) begin
					// move every row up, bottom row keeps its colours
					scrolls++;
					for (int k = 0; k < CELLS - COLS; k++) begin
						chars[k]  = chars[k + COLS];
						colors[k] = colors[k + COLS];
					end
					for (int k = CELLS - COLS; k < CELLS; k++)
						chars[k] = stcb_pkg::CHAR_SPACE;
					cursor = CELLS - COLS;
				end
				chars[cursor]  = c;
				colors[cursor] = in_brackets ? accent_pen : plain_pen;
				cursor++;
			end
		endfunction

		function void note_input(logic [1:0] m, logic [stcb_pkg::CHAR_W-1:0] c, logic eos,
				logic [2:0] row, logic [3:0] col);
			console_result_t res;
			res = '0;
			case (m)
				stcb_pkg::MODE_PUT: begin
					place_char(c);
					if (eos)
						in_brackets = 1'b0;
				end
				stcb_pkg::MODE_READ: begin
					reads++;
					if (row < LINES && col < COLS) begin
						res.ch    = chars[row * COLS + col];
						res.color = colors[row * COLS + col];
					end
				end
				stcb_pkg::MODE_CLEAR: begin
					clears++;
					wipe_store();
				end
				default: ;
			endcase
			res.pos = cursor[stcb_pkg::POS_W-1:0];
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [stcb_pkg::POS_W-1:0] pos,
				logic [stcb_pkg::CHAR_W-1:0] ch, logic [stcb_pkg::COLOR_W-1:0] color);
			console_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transaction pos=%0d char=%h color=%h",
					$time, pos, ch, color);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (pos !== want.pos) begin
				$display("%0t: cursor_pos expected %0d actual %0d", $time, want.pos, pos);
				errors++;
			end
			if (ch !== want.ch) begin
				$display("%0t: cell_char expected %h actual %h", $time, want.ch, ch);
				errors++;
			end
			if (color !== want.color) begin
				$display("%0t: cell_color expected %h actual %h", $time, want.color, color);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [stcb_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [stcb_pkg::COLOR_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] mode;
	logic [7:0] char_code;
	logic end_of_string;
	logic [2:0] read_row;
	logic [3:0] read_col;
	logic out_valid;
	logic out_stall;
	logic [stcb_pkg::POS_W-1:0] cursor_pos;
	logic [stcb_pkg::CHAR_W-1:0] cell_char;
	logic [stcb_pkg::COLOR_W-1:0] cell_color;

	console_scoreboard sb = new();

	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	bit hold_request = 1'b0;
	int items_sent = 0;
	int cfg_writes = 0;

	scrolling_text_console_buffer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.char_code    (char_code),
		.end_of_string(end_of_string),
		.read_row     (read_row),
		.read_col     (read_col),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.cursor_pos   (cursor_pos),
		.cell_char    (cell_char),
		.cell_color   (cell_color)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// all tasks are entered and left at a falling edge
	task automatic send_item(input logic [1:0] m, input logic [7:0] c, input logic eos,
			input logic [2:0] row, input logic [3:0] col);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode          = m;
		char_code     = c;
		end_of_string = eos;
		read_row      = row;
		read_col      = col;
		in_valid      = 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(m, c, eos, row, col);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic put_char(input logic [7:0] c, input logic eos);
		send_item(stcb_pkg::MODE_PUT, c, eos, 3'($urandom_range(0, 7)),
			4'($urandom_range(0, 15)));
	endtask

	task automatic read_cell(input logic [2:0] row, input logic [3:0] col);
		send_item(stcb_pkg::MODE_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			row, col);
	endtask

	task automatic write_register(input logic [stcb_pkg::CFG_INDEX_W-1:0] idx,
			input logic [stcb_pkg::COLOR_W-1:0] data);
		cfg_index = idx;
		cfg_data  = data;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering, let every result come back and the block go quiet
	task automatic settle();
		in_valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly printable text, bracketed runs, line ends, eos mostly on the last byte
	task automatic send_string();
		int len, r;
		logic [7:0] c;
		bit broken;
		len    = $urandom_range(1, 12);
		broken = ($urandom_range(0, 9) == 0);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				c = stcb_pkg::CHAR_LBRACKET;
			else if (r < 14)
				c = stcb_pkg::CHAR_RBRACKET;
			else if (r < 18)
				c = stcb_pkg::CHAR_LF;
			else if (r < 20)
				c = stcb_pkg::CHAR_CR;
			else if (r < 25)
				c = 8'($urandom_range(0, 255));
			else
				c = 8'($urandom_range(8'h21, 8'h7E));
			put_char(c, broken ? 1'($urandom_range(0, 1)) : (i == len - 1));
		end
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			send_string();
		else if (r < 85)
			read_cell(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
		else if (r < 89)
			send_item(MODE_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
				3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
		else if (r < 91)
			send_item(stcb_pkg::MODE_CLEAR, 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
				4'($urandom_range(0, 15)));
		else
			put_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin : result_sink
		int wait_cycles;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			wait_cycles = rx_idle ? $urandom_range(0, 6) : 0;
			if (hold_request) begin
				hold_request = 1'b0;
				wait_cycles  = LONG_HOLD;
			end
			if (wait_cycles > 0) begin
				out_stall = 1'b1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			sb.check_result(cursor_pos, cell_char, cell_color);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int target, drain;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = stcb_pkg::REG_PLAIN_PEN;
		cfg_data      = '0;
		in_valid      = 1'b0;
		mode          = stcb_pkg::MODE_PUT;
		char_code     = '0;
		end_of_string = 1'b0;
		read_row      = '0;
		read_col      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_register(stcb_pkg::REG_PLAIN_PEN, 16'hFFFF);
		write_register(stcb_pkg::REG_ACCENT_PEN, 16'h0000);
		write_register(REG_SPARE_A, 16'h1234);
		write_register(REG_SPARE_B, 16'hFFFF);

		// directed: reset contents, zero byte, brackets, eos, line ends, scroll, clear
		read_cell(3'd0, 4'd0);
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b0);
		put_char(stcb_pkg::CHAR_LBRACKET, 1'b0);
		put_char(8'h78, 1'b0);
		put_char(stcb_pkg::CHAR_RBRACKET, 1'b0);
		put_char(stcb_pkg::CHAR_LBRACKET, 1'b1);
		put_char(8'h79, 1'b0);
		put_char(stcb_pkg::CHAR_CR, 1'b0);
		put_char(stcb_pkg::CHAR_LF, 1'b0);
		read_cell(3'd0, 4'd3);
		read_cell(3'd7, 4'd15);
		send_item(MODE_UNUSED, 8'hFF, 1'b1, 3'd7, 4'd15);
		for (int row = 1; row < LINES; row++) begin
			put_char(8'(8'h40 + row), 1'b0);
			put_char(stcb_pkg::CHAR_LF, 1'b0);
		end
		put_char(stcb_pkg::CHAR_LF, 1'b0);
		put_char(8'h53, 1'b1);
		read_cell(3'd6, 4'd0);
		send_item(stcb_pkg::MODE_CLEAR, 8'h00, 1'b0, 3'd0, 4'd0);
		read_cell(3'd7, 4'd0);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: begin
					write_register(stcb_pkg::REG_PLAIN_PEN, 16'h0000);
					write_register(stcb_pkg::REG_ACCENT_PEN, 16'hFFFF);
				end
				1: begin
					write_register(stcb_pkg::REG_PLAIN_PEN, 16'hFFFF);
					write_register(stcb_pkg::REG_ACCENT_PEN, 16'hFFFF);
				end
				2: begin
					write_register(stcb_pkg::REG_PLAIN_PEN, 16'h0000);
					write_register(stcb_pkg::REG_ACCENT_PEN, 16'h0000);
				end
				default: begin
					write_register(stcb_pkg::REG_PLAIN_PEN, 16'($urandom_range(0, 16'hFFFF)));
					write_register(stcb_pkg::REG_ACCENT_PEN, 16'($urandom_range(0, 16'hFFFF)));
					if (phase == 5)
						write_register(REG_SPARE_A, 16'($urandom_range(0, 16'hFFFF)));
				end
			endcase
			// phase 2 runs with no idling on either side
			tx_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
			rx_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
			target  = items_sent + RANDOM_ITEMS / PHASES;
			if (phase == 4) begin
				// receiver holds off while the sender keeps pushing
				tx_idle      = 1'b0;
				hold_request = 1'b1;
				for (int k = 0; k < 40; k++)
					put_char(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
				tx_idle = 1'b1;
			end
			while (items_sent < target)
				send_random();
		end

		in_valid = 1'b0;
		drain    = 0;
		while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d transactions never came out", $time, sb.pending());
			sb.errors++;
		end

		$display("ran %0d items: %0d reads, %0d clears, %0d scrolls, %0d line ends",
			items_sent, sb.reads, sb.clears, sb.scrolls, sb.line_ends);
		$display("%0d results checked, %0d register writes, %0d mismatches",
			sb.checked, cfg_writes, sb.errors);
		if (sb.errors == 0)
			$display("scrolling_text_console_buffer_unit regression: pass");
		else
			$display("scrolling_text_console_buffer_unit regression: fail");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout at %0t", $time);
		$display("scrolling_text_console_buffer_unit regression: fail");
		$finish;
	end

endmodule
